// ----- hw/rtl/rid_pkg.sv -----
// ----------------------------------------------------------------------------
// rid_pkg
// Shared types, constants and helpers for the recent identifier duplicate
// filter: beat payloads, result codes and the store port bundle.
// ----------------------------------------------------------------------------
package rid_pkg;

  localparam int unsigned AttemptLimit = 8;
  localparam int unsigned StoreDepth   = 128;

  localparam int unsigned AddrW = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int unsigned CntW  = $clog2(StoreDepth + 1);
  localparam int unsigned AttW  = (AttemptLimit > 1) ? $clog2(AttemptLimit) : 1;
  localparam int unsigned IdW   = 128;

  typedef enum logic [2:0] {
    ST_ISSUED    = 3'd0,
    ST_ZERO      = 3'd1,
    ST_DUP       = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_FILLFAIL  = 3'd4
  } status_e;

  typedef struct packed {
    logic [63:0] id_upper;
    logic [63:0] id_lower;
    logic        fill_ok;
  } in_t;

  typedef struct packed {
    status_e    status;
    logic [2:0] attempt_index;
  } out_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [IdW-1:0]   wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic valid;
    out_t data;
  } res_t;

  // Report the low three bits of an attempt number of any width.
  function automatic logic [2:0] attempt_bits(input logic [AttW-1:0] att);
    logic [AttW+2:0] ext;
    ext = {3'b000, att};
    return ext[2:0];
  endfunction

endpackage

// ----- hw/rtl/rid_store.sv -----
// ----------------------------------------------------------------------------
// rid_store
// Recent identifier memory: one write port, one read port, registered read
// data. Contents are undefined until written.
// ----------------------------------------------------------------------------
module rid_store
  import rid_pkg::*;
(
  input  logic           clk_i,
  input  mem_req_t       req_i,
  output logic [IdW-1:0] rdata_o
);

  logic [IdW-1:0] mem [StoreDepth];
  logic [IdW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/rid_scan.sv -----
// ----------------------------------------------------------------------------
// rid_scan
// Sequencer that holds the candidate, walks the filled part of the store one
// entry per cycle up to a match, judges it and writes accepted ones back.
// ----------------------------------------------------------------------------
module rid_scan
  import rid_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  in_t            req_i,
  output logic           idle_o,
  output mem_req_t       mem_o,
  input  logic [IdW-1:0] rdata_i,
  output res_t           res_o,
  input  logic           slot_free_i
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e           state_q, state_d;
  in_t              cand_q, cand_d;
  logic             zero_q, zero_d;
  logic             hit_q, hit_d;
  logic             pend_q, pend_d;
  logic [CntW-1:0]  scan_q, scan_d;
  logic [CntW-1:0]  filled_q, filled_d;
  logic [AddrW-1:0] rptr_q, rptr_d;
  logic [AttW-1:0]  att_q, att_d;
  logic             req_zero;

  assign req_zero = (req_i.id_upper | req_i.id_lower) == 64'd0;
  assign idle_o   = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    cand_d    = cand_q;
    zero_d    = zero_q;
    hit_d     = hit_q;
    pend_d    = pend_q;
    scan_d    = scan_q;
    filled_d  = filled_q;
    rptr_d    = rptr_q;
    att_d     = att_q;
    mem_o     = '0;
    mem_o.wdata = {cand_q.id_upper, cand_q.id_lower};
    res_o     = '0;
    res_o.data.attempt_index = attempt_bits(att_q);

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cand_d = req_i;
          zero_d = req_zero;
          hit_d  = 1'b0;
          pend_d = 1'b0;
          scan_d = '0;
          if (!req_i.fill_ok || req_zero || filled_q == '0) begin
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        pend_d = 1'b0;
        if (pend_q && rdata_i == {cand_q.id_upper, cand_q.id_lower}) begin
          hit_d = 1'b1;
        end
        // Stop issuing reads once a match is seen; drain the one in flight.
        if (scan_q < filled_q && !hit_q) begin
          mem_o.re    = 1'b1;
          mem_o.raddr = scan_q[AddrW-1:0];
          scan_d      = scan_q + 1'b1;
          pend_d      = 1'b1;
        end else if (!pend_q) begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        res_o.valid = 1'b1;
        if (!cand_q.fill_ok) begin
          res_o.data.status = ST_FILLFAIL;
        end else if (zero_q || hit_q) begin
          if (att_q == AttW'(AttemptLimit - 1)) begin
            res_o.data.status = ST_EXHAUSTED;
          end else begin
            res_o.data.status = zero_q ? ST_ZERO : ST_DUP;
          end
        end else begin
          res_o.data.status = ST_ISSUED;
        end
        // Commit only when the output register takes the beat.
        if (slot_free_i) begin
          state_d = S_IDLE;
          if (res_o.data.status == ST_ZERO || res_o.data.status == ST_DUP) begin
            att_d = att_q + 1'b1;
          end else begin
            att_d = '0;
          end
          if (res_o.data.status == ST_ISSUED) begin
            mem_o.we = 1'b1;
            if (filled_q < CntW'(StoreDepth)) begin
              mem_o.waddr = filled_q[AddrW-1:0];
              filled_d    = filled_q + 1'b1;
            end else begin
              mem_o.waddr = rptr_q;
              rptr_d = (rptr_q == AddrW'(StoreDepth - 1)) ? '0 : rptr_q + 1'b1;
            end
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      hit_q    <= 1'b0;
      pend_q   <= 1'b0;
      scan_q   <= '0;
      filled_q <= '0;
      rptr_q   <= '0;
      att_q    <= '0;
    end else begin
      state_q  <= state_d;
      hit_q    <= hit_d;
      pend_q   <= pend_d;
      scan_q   <= scan_d;
      filled_q <= filled_d;
      rptr_q   <= rptr_d;
      att_q    <= att_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
    zero_q <= zero_d;
  end

`ifndef NO_ASSERTIONS
  a_filled_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= CntW'(StoreDepth))
    else $error("fill count beyond store depth");

  a_att_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    att_q <= AttW'(AttemptLimit - 1))
    else $error("attempt count beyond limit");

  a_ring_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rptr_q != '0) |-> (filled_q == CntW'(StoreDepth)))
    else $error("replacement pointer moved before store filled");

  a_commit_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && slot_free_i) |=> (state_q == S_IDLE))
    else $error("sequencer did not return to idle after result");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_o.we && (mem_o.re || pend_q && state_q == S_SCAN)))
    else $error("store write overlaps a scan read");
`endif

endmodule

// ----- hw/rtl/recent_id_duplicate_filter.sv -----
// ----------------------------------------------------------------------------
// recent_id_duplicate_filter
// Filters 128-bit candidate identifiers against a ring of recently issued
// ones and reports one status beat per candidate.
//
//   channel | dir | handshake                  | payload
//   --------+-----+----------------------------+-------------------------
//   in      | in  | in_valid_i / in_stall_o    | in_data_i  (rid_pkg::in_t)
//   out     | out | out_valid_o / out_stall_i  | out_data_o (rid_pkg::out_t)
//
// A candidate's scan walks the store's single read port one entry per cycle
// over the filled part and stops early on a match. Zero, fill-failed and
// empty-store cases skip the scan.
// After reset the store is empty; no clearing pass is needed.
// in_stall_o is high while a candidate is in work; a stalled output holds
// its beat and the next candidate may be taken meanwhile.
// ----------------------------------------------------------------------------
module recent_id_duplicate_filter
  import rid_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  mem_req_t       mem_req;
  logic [IdW-1:0] mem_rdata;
  res_t           res;
  logic           scan_idle;
  logic           slot_free;
  logic           out_valid_q;
  out_t           out_data_q;

  assign slot_free = !out_valid_q || !out_stall_i;

  rid_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_i       (in_data_i),
    .idle_o      (scan_idle),
    .mem_o       (mem_req),
    .rdata_i     (mem_rdata),
    .res_o       (res),
    .slot_free_i (slot_free)
  );

  rid_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Output register: load a new beat when free, drop a taken one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && slot_free) begin
      out_data_q <= res.data;
    end
  end

  assign in_stall_o  = !scan_idle;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- bench/recent_id_duplicate_filter_tb.sv -----
// ----------------------------------------------------------------------------
// recent_id_duplicate_filter_tb
// Drives candidate identifiers into the duplicate filter and checks every
// status beat against its typed table row or a recent-identifier predictor.
// A table of directed beats comes first. Random beats follow, weighted toward
// duplicates, zero candidates, runs of rejects and evicted identifiers.
// Both channels stall at random, and one long output hold-off fills the block.
// ----------------------------------------------------------------------------
module recent_id_duplicate_filter_tb;
  import rid_pkg::*;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] TOP_BIT  = 64'h8000_0000_0000_0000;
  localparam int unsigned RANDOM_BEATS = 1780;
  localparam int unsigned DRAIN_CYCLES = 140;

  typedef struct {
    logic [63:0] up;
    logic [63:0] lo;
    logic        ok;
    bit          typed;
    status_e     st;
    logic [2:0]  idx;
  } plan_row_t;

  localparam int unsigned PLAN_ROWS = 24;

  plan_row_t plan_rows [PLAN_ROWS] = '{
    '{64'd0,    64'd0,                  1'b0, 1'b1, ST_FILLFAIL,  3'd0},
    '{64'd0,    64'd0,                  1'b1, 1'b1, ST_ZERO,      3'd0},
    '{ALL_ONES, ALL_ONES,               1'b1, 1'b1, ST_ISSUED,    3'd1},
    '{ALL_ONES, ALL_ONES,               1'b1, 1'b1, ST_DUP,       3'd0},
    '{64'd0,    64'd0,                  1'b1, 1'b1, ST_ZERO,      3'd1},
    '{ALL_ONES, ALL_ONES,               1'b1, 1'b1, ST_DUP,       3'd2},
    '{64'd0,    64'd0,                  1'b1, 1'b1, ST_ZERO,      3'd3},
    '{ALL_ONES, ALL_ONES,               1'b1, 1'b1, ST_DUP,       3'd4},
    '{64'd0,    64'd0,                  1'b1, 1'b1, ST_ZERO,      3'd5},
    '{64'd0,    64'd0,                  1'b1, 1'b1, ST_ZERO,      3'd6},
    '{ALL_ONES, ALL_ONES,               1'b1, 1'b1, ST_EXHAUSTED, 3'd7},
    '{ALL_ONES, ALL_ONES,               1'b1, 1'b1, ST_DUP,       3'd0},
    '{ALL_ONES, ALL_ONES,               1'b0, 1'b1, ST_FILLFAIL,  3'd1},
    '{64'd1,    64'd0,                  1'b1, 1'b1, ST_ISSUED,    3'd0},
    '{64'd0,    64'd1,                  1'b1, 1'b1, ST_ISSUED,    3'd0},
    '{TOP_BIT,  64'd0,                  1'b1, 1'b1, ST_ISSUED,    3'd0},
    '{64'd0,    TOP_BIT,                1'b1, 1'b1, ST_ISSUED,    3'd0},
    '{ALL_ONES, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b1, ST_ISSUED,   3'd0},
    '{64'd0,    64'd1,                  1'b1, 1'b1, ST_DUP,       3'd0},
    '{64'd1,    64'd0,                  1'b0, 1'b1, ST_FILLFAIL,  3'd1},
    '{ALL_ONES, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b1, ST_DUP,      3'd0},
    '{64'd0,    64'd0,                  1'b1, 1'b1, ST_ZERO,      3'd1},
    '{64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b1, 1'b0, ST_ISSUED, 3'd0},
    '{64'd1,    64'd1,                  1'b1, 1'b0, ST_ISSUED,    3'd0}
  };

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  // Predictor state: the ring of recently issued identifiers.
  logic [IdW-1:0] recent_ids [StoreDepth];
  int unsigned    ids_held;
  int unsigned    ring_ptr;
  int unsigned    attempt_no;
  logic [IdW-1:0] issued_log [$];

  out_t        expected_results [$];
  out_t        want_res;
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned items_sent;
  int unsigned reject_burst;
  int unsigned hold_left;
  bit          hold_done;

  recent_id_duplicate_filter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #30_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic out_t judge_candidate(input in_t c);
    out_t           r;
    logic [IdW-1:0] id;
    bit             hit;
    id = {c.id_upper, c.id_lower};
    r.attempt_index = 3'(attempt_no);
    hit = 1'b0;
    for (int i = 0; i < ids_held; i++) begin
      if (recent_ids[i] == id) hit = 1'b1;
    end
    if (!c.fill_ok) begin
      r.status = ST_FILLFAIL;
      attempt_no = 0;
    end else if (id == '0 || hit) begin
      if (attempt_no + 1 >= AttemptLimit) begin
        r.status = ST_EXHAUSTED;
        attempt_no = 0;
      end else begin
        r.status = (id == '0) ? ST_ZERO : ST_DUP;
        attempt_no++;
      end
    end else begin
      // Fill empty slots first, then overwrite the oldest in ring order.
      if (ids_held < StoreDepth) begin
        recent_ids[ids_held] = id;
        ids_held++;
      end else begin
        recent_ids[ring_ptr] = id;
        ring_ptr = (ring_ptr + 1) % StoreDepth;
      end
      issued_log.push_back(id);
      r.status = ST_ISSUED;
      attempt_no = 0;
    end
    return r;
  endfunction

  function automatic logic [IdW-1:0] held_id();
    if (ids_held == 0) return {$urandom, $urandom, $urandom, $urandom};
    return recent_ids[$urandom_range(ids_held - 1, 0)];
  endfunction

  function automatic bit calm_stretch();
    return items_sent >= 1000 && items_sent < 1200;
  endfunction

  function automatic in_t pick_candidate();
    in_t            c;
    int unsigned    roll;
    logic [IdW-1:0] id;
    id = {$urandom, $urandom, $urandom, $urandom};
    // Start a run of rejects now and then so requests get exhausted.
    if (reject_burst == 0 && $urandom_range(99) < 4) reject_burst = $urandom_range(10, 5);
    if (reject_burst > 0) begin
      reject_burst--;
      roll = ($urandom_range(3) == 0) ? 10 : 20;
    end else begin
      roll = $urandom_range(99);
    end
    c.fill_ok = 1'b1;
    if (roll < 7) begin
      c.fill_ok = 1'b0;
      if ($urandom_range(1) == 1) id = held_id();
    end else if (roll < 13) begin
      id = '0;
    end else if (roll < 38) begin
      id = held_id();
    end else if (roll < 44 && issued_log.size() > 0) begin
      id = issued_log[$urandom_range(issued_log.size() - 1, 0)];
    end else if (roll < 50) begin
      id = held_id() ^ (IdW'(1) << $urandom_range(IdW - 1, 0));
    end
    {c.id_upper, c.id_lower} = id;
    return c;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endtask

  task automatic send_beat(input in_t beat, input bit typed, input out_t typed_res);
    int unsigned gap;
    out_t        model_res;
    gap = 0;
    if (!calm_stretch()) begin
      if ($urandom_range(99) < 4) gap = $urandom_range(150, 1);
      while ($urandom_range(99) < 38) gap++;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    model_res = judge_candidate(beat);
    expected_results.push_back(typed ? typed_res : model_res);
    items_sent++;
  endtask

  initial begin : stimulus
    in_t  beat;
    out_t row_res;
    in_valid_i   <= 1'b0;
    in_data_i    <= '0;
    ids_held     = 0;
    ring_ptr     = 0;
    attempt_no   = 0;
    mismatches   = 0;
    results_seen = 0;
    items_sent   = 0;
    reject_burst = 0;
    @(posedge rst_ni);
    @(posedge clk_i);
    foreach (plan_rows[r]) begin
      beat.id_upper         = plan_rows[r].up;
      beat.id_lower         = plan_rows[r].lo;
      beat.fill_ok          = plan_rows[r].ok;
      row_res.status        = plan_rows[r].st;
      row_res.attempt_index = plan_rows[r].idx;
      send_beat(beat, plan_rows[r].typed, row_res);
    end
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      send_beat(pick_candidate(), 1'b0, row_res);
    end
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : receiver
    out_stall_i <= 1'b0;
    hold_left   = 0;
    hold_done   = 1'b0;
    forever begin
      @(posedge clk_i);
      // Hold the output once for a long stretch while beats keep coming.
      if (!hold_done && items_sent >= 400) begin
        hold_done = 1'b1;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (calm_stretch()) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < 38);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        flag_mismatch($sformatf("beat %0d with nothing expected: status %0d index %0d",
                                results_seen, out_data_o.status, out_data_o.attempt_index));
      end else begin
        want_res = expected_results.pop_front();
        if (out_data_o.status !== want_res.status) begin
          flag_mismatch($sformatf("beat %0d status: expected %0d, got %0d",
                                  results_seen, want_res.status, out_data_o.status));
        end
        if (out_data_o.attempt_index !== want_res.attempt_index) begin
          flag_mismatch($sformatf("beat %0d attempt index: expected %0d, got %0d",
                                  results_seen, want_res.attempt_index,
                                  out_data_o.attempt_index));
        end
      end
    end
  end

endmodule

// ----- files.f -----
hw/rtl/rid_pkg.sv
hw/rtl/rid_store.sv
hw/rtl/rid_scan.sv
hw/rtl/recent_id_duplicate_filter.sv
bench/recent_id_duplicate_filter_tb.sv
